>>> rtl/pair_midpoint_pose_to_odom_frame_macros.svh
// Assertion macros for the pair midpoint pose block.
// Included by the top level; no other dependencies.
`ifndef PAIR_MIDPOINT_POSE_TO_ODOM_FRAME_MACROS_SVH
`define PAIR_MIDPOINT_POSE_TO_ODOM_FRAME_MACROS_SVH
`ifndef SYNTHESIS
`define PMP_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");
`define PMP_ASSERT_AFTER(lbl, clk, rst, ante, n, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
      else $error("assertion failed");
`else
`define PMP_ASSERT_NEVER(lbl, clk, rst, expr)
`define PMP_ASSERT_AFTER(lbl, clk, rst, ante, n, cons)
`endif
`endif

>>> rtl/pmp_pkg.sv
// Shared types and constants for the pair midpoint pose block.
// No dependencies.
`timescale 1ns / 1ps
package pmp_pkg;
   typedef struct packed {
      logic signed [31:0] first_x;
      logic signed [31:0] first_y;
      logic signed [31:0] second_x;
      logic signed [31:0] second_y;
      logic signed [31:0] odom_origin_x;
      logic signed [31:0] odom_origin_y;
      logic signed [15:0] odom_yaw;
   } req_type;

   typedef struct packed {
      logic signed [31:0] mid_x;
      logic signed [31:0] mid_y;
      logic signed [15:0] heading;
      logic signed [31:0] local_x;
      logic signed [31:0] local_y;
      logic signed [15:0] relative_yaw;
   } rsp_type;

   // Front-end result handed to the CORDIC back end
   typedef struct packed {
      logic signed [31:0] mid_x;
      logic signed [31:0] mid_y;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [32:0] off_x;
      logic signed [32:0] off_y;
      logic signed [15:0] yaw;
      logic               same_pos;
   } work_type;

   localparam int GUARD_BITS = 24;
   localparam int VEC_W = 60;
   localparam logic signed [30:0] INV_GAIN_Q30 = 31'sd652032875;

   localparam logic [31:0] ATAN_TURN32 [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

   // Arctangent of 2^-i, rounded to nearest at ab bits per turn
   function automatic logic [31:0] atan_step(input int i, input int ab);
      logic [63:0] t;
      int sh;
      sh = 32 - ab;
      t = {32'd0, ATAN_TURN32[i % 32]};
      t = (t + (64'd1 << (sh - 1))) >> sh;
      return t[31:0];
   endfunction
endpackage

>>> rtl/pmp_front.sv
// Front end: takes a request, forms midpoint, difference and offset vectors.
// Depends on pmp_pkg.
`timescale 1ns / 1ps
module pmp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  pmp_pkg::req_type req_item,
   output logic             work_valid,
   output pmp_pkg::work_type work_item
);
   logic                 valid_ff;
   pmp_pkg::work_type    work_ff, work_in;
   logic signed [32:0]   sum_x, sum_y;

   always_comb begin
      sum_x = 33'(req_item.first_x) + 33'(req_item.second_x);
      sum_y = 33'(req_item.first_y) + 33'(req_item.second_y);
      work_in.mid_x = sum_x[32:1];
      work_in.mid_y = sum_y[32:1];
      work_in.dx = 33'(req_item.second_x) - 33'(req_item.first_x);
      work_in.dy = 33'(req_item.second_y) - 33'(req_item.first_y);
      work_in.off_x = 33'($signed(sum_x[32:1])) - 33'(req_item.odom_origin_x);
      work_in.off_y = 33'($signed(sum_y[32:1])) - 33'(req_item.odom_origin_y);
      work_in.yaw = req_item.odom_yaw;
      work_in.same_pos = (req_item.first_x == req_item.second_x) &&
                         (req_item.first_y == req_item.second_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= take;
      end
      if (take) begin
         work_ff <= work_in;
      end
   end

   assign work_valid = valid_ff;
   assign work_item  = work_ff;
endmodule

>>> rtl/pmp_queue.sv
// Two-entry request queue between front end and CORDIC back end.
// Depends on pmp_pkg.
`timescale 1ns / 1ps
module pmp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pmp_pkg::work_type push_item,
   output logic              pop_valid,
   output pmp_pkg::work_type pop_item,
   output logic              full
);
   pmp_pkg::work_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              pop;

   always_comb begin
      pop = (count_ff != 2'd0);
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_valid = pop;
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign full      = (count_ff == 2'd2);
endmodule

>>> rtl/pmp_back.sv
// Back end: pipelined vectoring CORDIC (heading) and rotation CORDIC (local pose).
// Depends on pmp_pkg.
`timescale 1ns / 1ps
module pmp_back #(
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  pmp_pkg::work_type in_item,
   output logic              out_valid,
   output pmp_pkg::rsp_type  out_item
);
   localparam int VW   = pmp_pkg::VEC_W;
   localparam int GB   = pmp_pkg::GUARD_BITS;
   localparam int AB   = ANGLE_BITS;
   localparam int KUP  = (AB > 16) ? AB - 16 : 1;
   localparam int KDN  = (AB < 16) ? 16 - AB : 1;
   localparam int NS   = CORDIC_STEPS;
   localparam logic signed [AB-1:0] HALF_TURN    = {1'b1, {(AB-1){1'b0}}};
   localparam logic signed [AB-1:0] QUARTER_TURN = {2'b01, {(AB-2){1'b0}}};

   typedef struct packed {
      logic signed [31:0] mid_x;
      logic signed [31:0] mid_y;
      logic signed [15:0] yaw;
      logic               same_pos;
   } pass_type;

   // stage A
   logic               a_valid_ff;
   pass_type           a_pass_ff;
   logic signed [VW-1:0] a_vx_ff, a_vy_ff, a_rx_ff, a_ry_ff;
   logic signed [AB-1:0] a_vz_ff, a_rz_ff;
   logic signed [63:0]   prod_x, prod_y;
   logic signed [VW-1:0] vx_in, vy_in;
   logic signed [AB-1:0] vz_in, rz_in, yaw_ab;

   always_comb begin
      prod_x = 64'(in_item.off_x) * 64'(pmp_pkg::INV_GAIN_Q30);
      prod_y = 64'(in_item.off_y) * 64'(pmp_pkg::INV_GAIN_Q30);
      vx_in = VW'(in_item.dx) <<< GB;
      vy_in = VW'(in_item.dy) <<< GB;
      vz_in = '0;
      // left half-plane: negate and add a half turn
      if (in_item.dx < 0) begin
         vx_in = -vx_in;
         vy_in = -vy_in;
         vz_in = HALF_TURN;
      end
      if (AB >= 16) begin
         yaw_ab = AB'($signed({{8{in_item.yaw[15]}}, in_item.yaw}) <<< (AB - 16));
      end else begin
         yaw_ab = AB'(in_item.yaw >>> KDN);
      end
      rz_in = -yaw_ab;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
      a_pass_ff <= '{in_item.mid_x, in_item.mid_y, in_item.yaw, in_item.same_pos};
      a_vx_ff <= vx_in;
      a_vy_ff <= vy_in;
      a_vz_ff <= vz_in;
      a_rx_ff <= VW'(prod_x >>> 6);
      a_ry_ff <= VW'(prod_y >>> 6);
      a_rz_ff <= rz_in;
   end

   // stage arrays: index 0 is stage B output, index NS after the last iteration
   logic               s_valid_ff [NS+1];
   pass_type           s_pass_ff  [NS+1];
   logic signed [VW-1:0] s_vx_ff [NS+1], s_vy_ff [NS+1];
   logic signed [VW-1:0] s_rx_ff [NS+1], s_ry_ff [NS+1];
   logic signed [AB-1:0] s_vz_ff [NS+1], s_rz_ff [NS+1];

   // stage B: fold rotations wider than a quarter turn
   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff[0] <= 1'b0;
      end else begin
         s_valid_ff[0] <= a_valid_ff;
      end
      s_pass_ff[0] <= a_pass_ff;
      s_vx_ff[0] <= a_vx_ff;
      s_vy_ff[0] <= a_vy_ff;
      s_vz_ff[0] <= a_vz_ff;
      if (a_rz_ff > QUARTER_TURN || a_rz_ff < -QUARTER_TURN) begin
         s_rx_ff[0] <= -a_rx_ff;
         s_ry_ff[0] <= -a_ry_ff;
         s_rz_ff[0] <= a_rz_ff - HALF_TURN;
      end else begin
         s_rx_ff[0] <= a_rx_ff;
         s_ry_ff[0] <= a_ry_ff;
         s_rz_ff[0] <= a_rz_ff;
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_step
      localparam logic signed [AB-1:0] ATAN = AB'(pmp_pkg::atan_step(i, AB));
      logic signed [VW-1:0] vxs, vys, rxs, rys;
      always_comb begin
         vxs = s_vx_ff[i] >>> i;
         vys = s_vy_ff[i] >>> i;
         rxs = s_rx_ff[i] >>> i;
         rys = s_ry_ff[i] >>> i;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            s_valid_ff[i+1] <= 1'b0;
         end else begin
            s_valid_ff[i+1] <= s_valid_ff[i];
         end
         s_pass_ff[i+1] <= s_pass_ff[i];
         if (s_vy_ff[i] >= 0) begin
            s_vx_ff[i+1] <= s_vx_ff[i] + vys;
            s_vy_ff[i+1] <= s_vy_ff[i] - vxs;
            s_vz_ff[i+1] <= s_vz_ff[i] + ATAN;
         end else begin
            s_vx_ff[i+1] <= s_vx_ff[i] - vys;
            s_vy_ff[i+1] <= s_vy_ff[i] + vxs;
            s_vz_ff[i+1] <= s_vz_ff[i] - ATAN;
         end
         if (s_rz_ff[i] >= 0) begin
            s_rx_ff[i+1] <= s_rx_ff[i] - rys;
            s_ry_ff[i+1] <= s_ry_ff[i] + rxs;
            s_rz_ff[i+1] <= s_rz_ff[i] - ATAN;
         end else begin
            s_rx_ff[i+1] <= s_rx_ff[i] + rys;
            s_ry_ff[i+1] <= s_ry_ff[i] - rxs;
            s_rz_ff[i+1] <= s_rz_ff[i] + ATAN;
         end
      end
   end

   // output stage: round, saturate, convert heading
   logic               out_valid_ff;
   pmp_pkg::rsp_type   out_ff, out_in;
   logic signed [AB-1:0]   z_fin;
   logic signed [AB:0]     z_rnd;
   logic signed [15:0]     hd;
   logic signed [VW-GB-1:0] lx_w, ly_w;
   logic signed [VW-1:0]   lx_r, ly_r;

   function automatic logic signed [31:0] sat32(input logic signed [VW-GB-1:0] v);
      if (v > $signed((VW-GB)'(32'sh7fffffff))) return 32'sh7fffffff;
      if (v < $signed((VW-GB)'(-64'sh80000000))) return 32'sh80000000;
      return v[31:0];
   endfunction

   always_comb begin
      z_fin = s_pass_ff[NS].same_pos ? '0 : s_vz_ff[NS];
      z_rnd = '0;
      if (AB > 16) begin
         z_rnd = ((AB+1)'(z_fin) + (AB+1)'(1 <<< (KUP - 1))) >>> KUP;
         hd = z_rnd[15:0];
      end else begin
         hd = 16'(z_fin) <<< (16 - AB);
      end
      lx_r = s_rx_ff[NS] + (VW'(1) <<< (GB - 1));
      ly_r = s_ry_ff[NS] + (VW'(1) <<< (GB - 1));
      lx_w = lx_r[VW-1:GB];
      ly_w = ly_r[VW-1:GB];
      out_in.mid_x = s_pass_ff[NS].mid_x;
      out_in.mid_y = s_pass_ff[NS].mid_y;
      out_in.heading = hd;
      out_in.local_x = sat32(lx_w);
      out_in.local_y = sat32(ly_w);
      out_in.relative_yaw = s_pass_ff[NS].yaw - hd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= s_valid_ff[NS];
      end
      out_ff <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_ff;
endmodule

>>> rtl/pair_midpoint_pose_to_odom_frame.sv
// Request path to rsp_valid: front-end register, queue, stage A, stage B, CORDIC steps, output.
// Throughput: one request per cycle; the two CORDIC pipelines are one stage per step.
// busy stays low since the back end drains its queue every cycle.
// Synchronous active-high reset clears all valid flags and queue pointers.
`timescale 1ns / 1ps
`include "pair_midpoint_pose_to_odom_frame_macros.svh"
module pair_midpoint_pose_to_odom_frame #(
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pmp_pkg::req_type req_item,
   output logic             rsp_valid,
   output pmp_pkg::rsp_type rsp_item
);
   logic              take, work_valid, q_valid, q_full;
   pmp_pkg::work_type work_item, q_item;

   assign take = start && !busy;
   assign busy = q_full;

   pmp_front u_front (
      .clock(clock), .reset(reset), .take(take), .req_item(req_item),
      .work_valid(work_valid), .work_item(work_item)
   );

   pmp_queue u_queue (
      .clock(clock), .reset(reset), .push(work_valid), .push_item(work_item),
      .pop_valid(q_valid), .pop_item(q_item), .full(q_full)
   );

   pmp_back #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock(clock), .reset(reset), .in_valid(q_valid), .in_item(q_item),
      .out_valid(rsp_valid), .out_item(rsp_item)
   );

   `PMP_ASSERT_NEVER(a_never_busy, clock, reset, busy)
   `PMP_ASSERT_AFTER(a_latency, clock, reset, take, CORDIC_STEPS + 5, rsp_valid)
endmodule
